// ===== hw/rtl/lrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants of the LZ/RLE byte decompressor.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int unsigned HIST_DEPTH_DEF = 4096;
  localparam int unsigned HIST_AW_MAX    = 16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNEXPECTED = 2'd1,
    ST_BAD_REF    = 2'd2
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       need_byte;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // Work handed from the decoder to the history side.
  typedef struct packed {
    logic                   src_hist;
    logic [HIST_AW_MAX-1:0] rd_addr;
    out_item_t              res;
  } lrd_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lrd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lrd_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [IW-1:0] rd_ptr;
  logic [IW-1:0] wr_ptr;
  logic [IW:0] cnt;
  logic do_push;
  logic do_pop;

  assign full    = (cnt == (IW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lrd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_front
// Command decoder: parses headers, tracks runs and output count, and issues
// one work entry per accepted item.
// ----------------------------------------------------------------------------
module lrd_front #(
  parameter int unsigned HISTORY_DEPTH = lrd_pkg::HIST_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire lrd_pkg::in_item_t item,
  input  wire logic [31:0]       size_limit,
  output lrd_pkg::lrd_cmd_t      cmd
);
  import lrd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    PH_CMD, PH_EXT1, PH_EXT2, PH_LIT, PH_FILL, PH_RUN
  } phase_t;

  phase_t phase, phase_next;
  logic [7:0] cmd_byte, cmd_byte_next;
  logic [7:0] ext_byte, ext_byte_next;
  logic [15:0] rem, rem_next;
  logic [11:0] cp_dist, cp_dist_next;
  logic [7:0] fill, fill_next;
  logic [31:0] produced, produced_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;

  always_comb begin
    logic done_before;
    logic run_go;
    logic [15:0] run_len;
    logic [11:0] run_dist;
    logic [7:0] e;
    logic [7:0] x2;
    logic [3:0] nib;
    logic emit;
    logic [7:0] obyte;
    logic [1:0] st;
    logic hist;
    logic [AW:0] raddr;
    logic done;
    phase_next    = phase;
    cmd_byte_next = cmd_byte;
    ext_byte_next = ext_byte;
    rem_next      = rem;
    cp_dist_next  = cp_dist;
    fill_next     = fill;
    produced_next = produced;
    wr_ptr_next   = wr_ptr;
    run_go   = 1'b0;
    run_len  = '0;
    run_dist = '0;
    e        = ext_byte;
    x2       = 8'd0;
    nib      = item.in_byte[7:4];
    emit     = 1'b0;
    obyte    = 8'd0;
    st       = ST_OK;
    hist     = 1'b0;
    raddr    = '0;
    done_before = (phase == PH_CMD) && (produced >= size_limit);

    if (done_before) begin
      st = ST_UNEXPECTED;
    end else if (!item.req_type) begin
      case (phase)
        PH_CMD: begin
          cmd_byte_next = item.in_byte;
          case (nib) inside
            4'h0, 4'h1: begin
              rem_next   = {11'd0, item.in_byte[4:0]} + 16'd1;
              phase_next = PH_LIT;
            end
            4'h2: begin
              run_go  = 1'b1;
              run_len = {12'd0, item.in_byte[3:0]} + 16'd1;
            end
            4'h3: phase_next = PH_FILL;
            [4'h4:4'h7]: begin
              run_go   = 1'b1;
              run_len  = {13'd0, item.in_byte[2:0]} + 16'd2;
              run_dist = {9'd0, item.in_byte[5:3]} + 12'd1;
            end
            4'hC, 4'hD: begin
              run_go   = 1'b1;
              run_len  = {14'd0, item.in_byte[1:0]} + 16'd2;
              run_dist = {9'd0, item.in_byte[4:2]} + 12'd1;
            end
            default: phase_next = PH_EXT1;
          endcase
        end
        PH_EXT1, PH_EXT2: begin
          if (phase == PH_EXT1) begin
            ext_byte_next = item.in_byte;
            e = item.in_byte;
          end else begin
            x2 = item.in_byte;
          end
          if (phase == PH_EXT1 && (cmd_byte[7:4] == 4'hA || cmd_byte[7:4] == 4'hB ||
                                   cmd_byte[7:4] == 4'hF)) begin
            phase_next = PH_EXT2;
          end else begin
            run_go = 1'b1;
            case (cmd_byte[7:4])
              4'h8, 4'hE: begin
                run_len  = {10'd0, e[5:0]} + 16'd3;
                run_dist = {6'd0, cmd_byte[3:0], e[7:6]} + 12'd1;
              end
              4'h9: begin
                run_len  = {14'd0, e[1:0]} + 16'd3;
                run_dist = {2'd0, cmd_byte[3:0], e[7:2]} + 12'd1;
              end
              4'hA: begin
                run_len  = {e, x2};
                run_dist = {8'd0, cmd_byte[3:0]} + 12'd1;
              end
              default: begin
                run_len  = {6'd0, e[1:0], x2} + 16'd4;
                run_dist = {2'd0, cmd_byte[3:0], e[7:2]} + 12'd1;
              end
            endcase
          end
        end
        PH_LIT: begin
          emit     = 1'b1;
          obyte    = item.in_byte;
          rem_next = rem - 16'd1;
          if (rem_next == 16'd0) begin
            phase_next = PH_CMD;
          end
        end
        PH_FILL: begin
          fill_next = item.in_byte;
          run_go    = 1'b1;
          run_len   = {12'd0, cmd_byte[3:0]} + 16'd3;
        end
        default: st = ST_UNEXPECTED;
      endcase
    end else if (phase == PH_RUN) begin
      emit = 1'b1;
      if (cmd_byte[7:4] == 4'h3) begin
        obyte = fill;
      end else if (cmd_byte[7:4] != 4'h2) begin
        if (cp_dist == 12'd0 || {20'd0, cp_dist} > produced) begin
          st = ST_BAD_REF;
        end else begin
          hist = 1'b1;
          if ({1'b0, wr_ptr} >= (AW+1)'(cp_dist)) begin
            raddr = {1'b0, wr_ptr} - (AW+1)'(cp_dist);
          end else begin
            raddr = {1'b0, wr_ptr} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(cp_dist);
          end
        end
        if (cmd_byte[7:6] == 2'b11) begin
          cp_dist_next = cp_dist + 12'd2;
        end
      end
      rem_next = rem - 16'd1;
      if (rem_next == 16'd0) begin
        phase_next = PH_CMD;
      end
    end else begin
      st = ST_UNEXPECTED;
    end

    if (run_go) begin
      rem_next     = run_len;
      cp_dist_next = run_dist;
      phase_next   = (run_len == 16'd0) ? PH_CMD : PH_RUN;
    end

    if (emit) begin
      wr_ptr_next = (wr_ptr == AW'(HISTORY_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (produced != 32'hFFFF_FFFF) begin
        produced_next = produced + 32'd1;
      end
    end

    done = (phase_next == PH_CMD) && (produced_next >= size_limit);
    cmd.src_hist      = hist;
    cmd.rd_addr       = HIST_AW_MAX'(raddr[AW-1:0]);
    cmd.res.out_valid = emit;
    cmd.res.out_byte  = obyte;
    cmd.res.need_byte = !done && (phase_next != PH_RUN);
    cmd.res.done_res  = done;
    cmd.res.status    = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CMD;
      cmd_byte <= '0;
      ext_byte <= '0;
      rem      <= '0;
      cp_dist  <= '0;
      fill     <= '0;
      produced <= '0;
      wr_ptr   <= '0;
    end else if (take) begin
      phase    <= phase_next;
      cmd_byte <= cmd_byte_next;
      ext_byte <= ext_byte_next;
      rem      <= rem_next;
      cp_dist  <= cp_dist_next;
      fill     <= fill_next;
      produced <= produced_next;
      wr_ptr   <= wr_ptr_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lrd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_back
// History side: reads copy sources from the history memory, forwards the
// byte written in the same cycle, and records every emitted byte.
// ----------------------------------------------------------------------------
module lrd_back #(
  parameter int unsigned HISTORY_DEPTH = lrd_pkg::HIST_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lrd_pkg::lrd_cmd_t q_cmd,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output lrd_pkg::out_item_t     res,
  output logic                   res_push,
  input  wire logic              res_full
);
  import lrd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [7:0] hist [HISTORY_DEPTH];
  logic [7:0] mem_q;
  logic s2_valid;
  lrd_cmd_t s2_cmd;
  logic byp_hit;
  logic [7:0] byp_byte;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_addr;
  logic s2_go;
  logic wr_en;
  logic [7:0] wr_byte;

  assign rd_addr = q_cmd.rd_addr[AW-1:0];
  assign s2_go   = s2_valid && !res_full;
  assign q_pop   = !q_empty && (!s2_valid || s2_go);
  assign wr_byte = s2_cmd.src_hist ? (byp_hit ? byp_byte : mem_q) : s2_cmd.res.out_byte;
  assign wr_en   = s2_go && s2_cmd.res.out_valid;

  always_comb begin
    res          = s2_cmd.res;
    res.out_byte = wr_byte;
  end
  assign res_push = s2_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      wr_ptr   <= '0;
    end else begin
      if (q_pop) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(HISTORY_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cmd   <= q_cmd;
      byp_hit  <= wr_en && (wr_ptr == rd_addr);
      byp_byte <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_ptr] <= wr_byte;
    end
    if (q_pop) begin
      mem_q <= hist[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lz_rle_byte_decompressor_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lz_rle_byte_decompressor_unit
// LZ77 decoder with run-length commands and a byte history memory.
// ----------------------------------------------------------------------------
//  channel   | ports                         | transfer when
//  input     | push, full, in_data           | push && !full
//  result    | pop, empty, out_data          | pop && !empty
//  config    | psel, penable, pwrite, paddr  | psel && penable && pwrite
//
// One item is accepted per cycle while full is low; its result reaches the result
// ports through the work queue, the history memory read register and the result
// queue. Reset clears all control state; the history memory is not cleared. A
// full result queue stalls the history side, and the work queue then fills and
// raises full.
// ----------------------------------------------------------------------------
module lz_rle_byte_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = lrd_pkg::HIST_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire lrd_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output lrd_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import lrd_pkg::*;

  logic [31:0] size_limit;
  logic take;
  lrd_cmd_t f_cmd;
  lrd_cmd_t q_cmd;
  logic q_empty;
  logic q_pop;
  out_item_t b_res;
  logic b_push;
  logic r_full;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? size_limit : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      size_limit <= pwdata;
    end
  end

  assign take = push && !full;

  lrd_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_data),
    .size_limit(size_limit),
    .cmd       (f_cmd)
  );

  lrd_fifo #(.W($bits(lrd_cmd_t)), .DEPTH(4)) u_work_q (
    .clk  (clk),
    .rst  (rst),
    .push (take),
    .wdata(f_cmd),
    .full (full),
    .pop  (q_pop),
    .rdata(q_cmd),
    .empty(q_empty)
  );

  lrd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (q_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (b_res),
    .res_push(b_push),
    .res_full(r_full)
  );

  lrd_fifo #(.W($bits(out_item_t)), .DEPTH(2)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (b_push),
    .wdata(b_res),
    .full (r_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

endmodule
`default_nettype wire

// ===== tb/tb_lz_rle_byte_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lz_rle_byte_decompressor_unit
// Self-checking bench for the LZ/RLE byte decompressor. Well-formed commands
// with random content and some noise are streamed through the input queue. A
// decoder model inside a scoreboard class predicts every result. Sender
// gaps, receiver stalls and output size limits vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_lz_rle_byte_decompressor_unit;
  import lrd_pkg::*;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [2:0] ADDR_SIZE_LIMIT = 3'd0;

  typedef enum int {
    PH_CMD, PH_EXT1, PH_EXT2, PH_LIT, PH_FILL, PH_RUN
  } dec_phase_t;

  class decode_scoreboard;
    dec_phase_t phase;
    logic [7:0] cmd;
    logic [7:0] ext;
    logic [15:0] remaining;
    logic [11:0] copy_dist;
    logic [7:0] fill;
    logic [31:0] produced;
    logic [31:0] exp_size;
    int unsigned wr_ptr;
    logic [7:0] hist [DEPTH];
    out_item_t pending [$];
    int errors;

    function void init();
      phase = PH_CMD;
      cmd = '0;
      ext = '0;
      remaining = '0;
      copy_dist = '0;
      fill = '0;
      produced = '0;
      exp_size = '0;
      wr_ptr = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void store(logic [7:0] b);
      hist[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
      if (produced != 32'hFFFF_FFFF) produced++;
    endfunction

    function void start_run(int unsigned len, int unsigned d);
      remaining = len[15:0];
      copy_dist = d[11:0];
      phase = (remaining == 0) ? PH_CMD : PH_RUN;
    endfunction

    function void decode_header(logic [7:0] f);
      int unsigned c;
      int unsigned e;
      c = cmd;
      e = ext;
      case (c >> 4)
        4'h8, 4'hE: start_run((e & 'h3F) + 3, ((((c & 'hF) << 2) | (e >> 6)) & 'h3F) + 1);
        4'h9: start_run((e & 3) + 3, ((((c & 'hF) << 6) | (e >> 2)) & 'h3FF) + 1);
        4'hA: start_run((e << 8) | f, (c & 'hF) + 1);
        default: start_run((((e & 3) << 8) | f) + 4,
                           ((((c & 'hF) << 6) | (e >> 2)) & 'h3FF) + 1);
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [3:0] nib;
      r = '0;
      r.status = ST_OK;
      nib = cmd[7:4];
      if (phase == PH_CMD && produced >= exp_size) begin
        r.status = ST_UNEXPECTED;
      end else if (!it.req_type) begin
        case (phase)
          PH_CMD: begin
            cmd = it.in_byte;
            case (it.in_byte[7:4])
              4'h0, 4'h1: begin
                remaining = {11'd0, it.in_byte[4:0]} + 16'd1;
                phase = PH_LIT;
              end
              4'h2: start_run(it.in_byte[3:0] + 1, 0);
              4'h3: phase = PH_FILL;
              4'h4, 4'h5, 4'h6, 4'h7: start_run(it.in_byte[2:0] + 2, it.in_byte[5:3] + 1);
              4'hC, 4'hD: start_run(it.in_byte[1:0] + 2, it.in_byte[4:2] + 1);
              default: phase = PH_EXT1;
            endcase
          end
          PH_EXT1: begin
            ext = it.in_byte;
            if (nib == 4'hA || nib == 4'hB || nib == 4'hF) phase = PH_EXT2;
            else decode_header(8'd0);
          end
          PH_EXT2: decode_header(it.in_byte);
          PH_LIT: begin
            r.out_valid = 1'b1;
            r.out_byte = it.in_byte;
            store(it.in_byte);
            remaining--;
            if (remaining == 0) phase = PH_CMD;
          end
          PH_FILL: begin
            fill = it.in_byte;
            start_run(cmd[3:0] + 3, 0);
          end
          default: r.status = ST_UNEXPECTED;
        endcase
      end else if (phase == PH_RUN) begin
        if (nib == 4'h2) begin
          r.out_byte = 8'd0;
        end else if (nib == 4'h3) begin
          r.out_byte = fill;
        end else begin
          if (copy_dist == 0 || copy_dist > produced) begin
            r.status = ST_BAD_REF;
            r.out_byte = 8'd0;
          end else begin
            r.out_byte = hist[(wr_ptr + DEPTH - copy_dist) % DEPTH];
          end
          if (nib >= 4'hC) copy_dist = copy_dist + 12'd2;
        end
        r.out_valid = 1'b1;
        store(r.out_byte);
        remaining--;
        if (remaining == 0) phase = PH_CMD;
      end else begin
        r.status = ST_UNEXPECTED;
      end
      r.done_res = (phase == PH_CMD) && (produced >= exp_size);
      r.need_byte = !r.done_res && phase != PH_RUN;
      pending = {pending, r};
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.out_valid !== want.out_valid) report($sformatf("out_valid %b want %b",
                                                          got.out_valid, want.out_valid));
      if (got.out_byte !== want.out_byte) report($sformatf("out_byte %h want %h",
                                                        got.out_byte, want.out_byte));
      if (got.need_byte !== want.need_byte) report($sformatf("need_byte %b want %b",
                                                          got.need_byte, want.need_byte));
      if (got.done_res !== want.done_res) report($sformatf("done_res %b want %b",
                                                        got.done_res, want.done_res));
      if (got.status !== want.status) report($sformatf("status %0d want %0d",
                                                    got.status, want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  decode_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned cycles = 0;

  lz_rle_byte_decompressor_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out_data);
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_data = it;
    do @(posedge clk); while (full);
    sb.note_input(it);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_size_limit(logic [31:0] v);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_SIZE_LIMIT;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.exp_size = v;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) sb.report($sformatf("size limit read %h want %h", prdata, v));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic in_item_t pick_item(bit noisy);
    in_item_t it;
    it.req_type = 1'b0;
    it.in_byte = 8'($urandom);
    if (noisy && $urandom_range(99) < 8) begin
      it.req_type = 1'($urandom);
    end else if (sb.phase == PH_RUN) begin
      it.req_type = 1'b1;
    end else if (sb.phase == PH_EXT1 && sb.cmd[7:4] == 4'hA) begin
      it.in_byte = ($urandom_range(9) == 0) ? 8'd1 : 8'd0;
    end else if (sb.phase == PH_EXT1 && (sb.cmd[7:4] == 4'hB || sb.cmd[7:4] == 4'hF)) begin
      it.in_byte[1:0] = ($urandom_range(9) == 0) ? 2'($urandom) : 2'd0;
    end
    return it;
  endfunction

  task automatic run_command(logic [7:0] c);
    send_item('{req_type: 1'b0, in_byte: c});
    while (sb.phase != PH_CMD) send_item(pick_item(1'b0));
  endtask

  task automatic random_items(int n);
    repeat (n) send_item(pick_item(1'b1));
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_item('{req_type: 1'b1, in_byte: 8'h00});
    write_size_limit(32'hFFFF_FFFF);
    send_item('{req_type: 1'b1, in_byte: 8'h00});
    run_command(8'h01);
    run_command(8'h20);
    send_item('{req_type: 1'b0, in_byte: 8'h30});
    send_item('{req_type: 1'b0, in_byte: 8'hFF});
    send_item('{req_type: 1'b0, in_byte: 8'h11});
    while (sb.phase != PH_CMD) send_item(pick_item(1'b0));
    run_command(8'h7F);
    run_command(8'h40);
    run_command(8'hC0);
    run_command(8'h8F);
    run_command(8'h90);
    send_item('{req_type: 1'b0, in_byte: 8'hA3});
    send_item('{req_type: 1'b0, in_byte: 8'h00});
    send_item('{req_type: 1'b0, in_byte: 8'h00});
    run_command(8'hB0);
    run_command(8'hDF);
    run_command(8'hE1);
    run_command(8'hF0);

    random_items(100);
    write_size_limit(sb.produced + 20);
    send_idle_pct = 79;
    random_items(100);
    write_size_limit(32'hFFFF_FFFF);
    random_items(10);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_items(100);
    write_size_limit(32'd0);
    random_items(5);
    write_size_limit(32'hFFFF_FFFF);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    random_items(100);

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/lrd_pkg.sv
hw/rtl/lrd_fifo.sv
hw/rtl/lrd_front.sv
hw/rtl/lrd_back.sv
hw/rtl/lz_rle_byte_decompressor_unit.sv
tb/tb_lz_rle_byte_decompressor_unit.sv
